[rtl/assert_macros.svh]
// Assertion helpers shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define VBA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When cond holds at one edge, post must hold at the following edge.
`define VBA_ASSERT_NEXT(lbl, clk, rst, cond, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (post)) else $error(msg);

`endif

[rtl/vba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vba_pkg;

  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int SLOT_W      = 4;
  localparam int CURSOR_W    = 49;
  localparam int FIRST_W     = 48;
  localparam int OFFSET_W    = 28;
  localparam int ORIGIN_W    = 16;
  localparam int BLOCK_W     = 8;
  localparam int SHAMT_W     = 5;
  localparam int GRID_W      = 9;
  localparam int LOG2_W      = 4;
  localparam int HEAD_EXT_W  = 9;

  localparam logic [GRID_W-1:0] GRID_RESET = 9'd16;
  localparam logic [GRID_W-1:0] GRID_MAX   = 9'd256;
  localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd3;
  localparam logic [LOG2_W-1:0] LOG2_MAX   = 4'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GRID = 1'b0,
    CFG_LOG2 = 1'b1
  } cfg_index_t;

  typedef enum logic {
    OP_GENERATE = 1'b0,
    OP_RELEASE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_GENERATED = 2'd0,
    STATUS_RELEASED  = 2'd1,
    STATUS_EXHAUSTED = 2'd2,
    STATUS_NO_SLOT   = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] release_slot;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [FIRST_W-1:0]  morton_first;
    logic [CURSOR_W-1:0] morton_past;
    logic [OFFSET_W-1:0] data_offset;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [ORIGIN_W-1:0] origin_z;
    logic [BLOCK_W-1:0]  block_x;
    logic [BLOCK_W-1:0]  block_y;
    logic [BLOCK_W-1:0]  block_z;
  } rsp_t;

  // Command to the free list: at most one of pop and push per cycle.
  typedef struct packed {
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] slot;
  } fl_cmd_t;

  // Geometry of the block that starts at the current cursor.
  typedef struct packed {
    logic [FIRST_W-1:0]  morton_first;
    logic [CURSOR_W-1:0] morton_past;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [ORIGIN_W-1:0] origin_z;
    logic [BLOCK_W-1:0]  block_x;
    logic [BLOCK_W-1:0]  block_y;
    logic [BLOCK_W-1:0]  block_z;
  } geom_t;

endpackage

`default_nettype wire

[rtl/vba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module vba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the contents from before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/vba_free_list.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vba_free_list #(
  parameter int POOL_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  vba_pkg::fl_cmd_t                  cmd,
  output logic [$clog2(POOL_SLOTS+1)-1:0]   head,
  output logic                              empty
);

  import vba_pkg::*;

  localparam int IDX_W  = $clog2(POOL_SLOTS);
  localparam int LINK_W = $clog2(POOL_SLOTS + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);

  // link always holds next_free[head]; the RAM port prefetches next_free[link].
  logic [LINK_W-1:0]     link;
  logic [POOL_SLOTS-1:0] valid;
  logic                  byp_hit;
  logic [LINK_W-1:0]     byp_data;
  logic                  rd_valid;

  logic [LINK_W-1:0] head_next;
  logic [LINK_W-1:0] link_next;
  logic [LINK_W-1:0] nf_link;
  logic              we;
  logic [IDX_W-1:0]  wa;
  logic [LINK_W-1:0] wd;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_in_range;
  logic [LINK_W-1:0] ram_q;

  always_comb begin
    // Entries never written still hold their reset link, index plus one.
    if (link >= NULL_LINK) begin
      nf_link = NULL_LINK;
    end else if (byp_hit) begin
      nf_link = byp_data;
    end else if (rd_valid) begin
      nf_link = ram_q;
    end else begin
      nf_link = link + LINK_W'(1);
    end

    head_next = head;
    link_next = link;
    we        = 1'b0;
    wa        = IDX_W'(cmd.slot);
    wd        = head;
    if (cmd.push) begin
      we        = 1'b1;
      head_next = LINK_W'(cmd.slot);
      link_next = head;
    end else if (cmd.pop) begin
      head_next = link;
      link_next = nf_link;
    end

    rd_in_range = (link_next < NULL_LINK);
    rd_addr     = rd_in_range ? IDX_W'(link_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      link     <= LINK_W'(1);
      valid    <= '0;
      byp_hit  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      head     <= head_next;
      link     <= link_next;
      if (we) begin
        valid[wa] <= 1'b1;
      end
      byp_hit  <= we && (wa == rd_addr) && rd_in_range;
      rd_valid <= valid[rd_addr] || (we && (wa == rd_addr));
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= wd;
  end

  vba_ram #(
    .WIDTH(LINK_W),
    .DEPTH(POOL_SLOTS)
  ) u_links (
    .clk  (clk),
    .we   (we),
    .waddr(wa),
    .wdata(wd),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  assign empty = (head >= NULL_LINK);

  `VBA_ASSERT_NEXT(a_push_sets_head, clk, rst, cmd.push, head == $past(LINK_W'(cmd.slot)), "push did not move the head")
  `VBA_ASSERT_NEXT(a_pop_follows_link, clk, rst, cmd.pop && !cmd.push, head == $past(link), "pop did not follow the link")

endmodule

`default_nettype wire

[rtl/vba_cursor.sv]
`timescale 1ns / 1ps
`default_nettype none

module vba_cursor #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic [vba_pkg::GRID_W-1:0]     grid_blocks_per_axis,
  input  logic [vba_pkg::LOG2_W-1:0]     block_width_log2,
  output logic                           exhausted,
  output logic [vba_pkg::SHAMT_W-1:0]    shamt,
  output vba_pkg::geom_t                 geom
);

  import vba_pkg::*;

  localparam int TW_W  = COORD_BITS + 17;
  localparam int IL_W  = 3 * COORD_BITS;
  localparam int CMP_W = 3 * COORD_BITS + CURSOR_W;
  localparam int AXW   = COORD_BITS + 16;

  logic [CURSOR_W-1:0] cursor;
  logic [CURSOR_W-1:0] step;
  logic [CURSOR_W-1:0] past;
  logic [LOG2_W-1:0]   lg;
  logic [GRID_W-1:0]   g;
  logic [TW_W-1:0]     tw_m1;
  logic [IL_W-1:0]     il;
  logic [CMP_W-1:0]    cur_pad;
  logic [AXW-1:0]      ax_x;
  logic [AXW-1:0]      ax_y;
  logic [AXW-1:0]      ax_z;

  always_comb begin
    lg    = (block_width_log2 > LOG2_MAX) ? LOG2_MAX : block_width_log2;
    g     = (grid_blocks_per_axis > GRID_MAX) ? GRID_MAX : grid_blocks_per_axis;
    shamt = SHAMT_W'(lg) + (SHAMT_W'(lg) << 1);
    step  = CURSOR_W'(1) << shamt;
    past  = cursor + step;

    // The last voxel of the grid, spread to every bit of its Morton triple,
    // is the highest code inside the grid.
    tw_m1 = (TW_W'(g) << lg) - TW_W'(1);
    for (int i = 0; i < COORD_BITS; i++) begin
      il[3*i +: 3] = {3{tw_m1[i]}};
    end
    exhausted = (g == '0) || (CMP_W'(cursor) > CMP_W'(il));

    // De-interleave: x from bit 0, y from bit 1, z from bit 2 of each triple.
    cur_pad = CMP_W'(cursor);
    ax_x    = '0;
    ax_y    = '0;
    ax_z    = '0;
    for (int i = 0; i < COORD_BITS; i++) begin
      ax_x[i] = cur_pad[3*i];
      ax_y[i] = cur_pad[3*i+1];
      ax_z[i] = cur_pad[3*i+2];
    end

    geom.morton_first = cursor[FIRST_W-1:0];
    geom.morton_past  = past;
    geom.origin_x     = ax_x[ORIGIN_W-1:0];
    geom.origin_y     = ax_y[ORIGIN_W-1:0];
    geom.origin_z     = ax_z[ORIGIN_W-1:0];
    geom.block_x      = BLOCK_W'(ax_x >> lg);
    geom.block_y      = BLOCK_W'(ax_y >> lg);
    geom.block_z      = BLOCK_W'(ax_z >> lg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (advance) begin
      cursor <= past;
    end
  end

endmodule

`default_nettype wire

[rtl/voxel_block_allocator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel  | Ports                          | Beat taken when
// ---------+--------------------------------+-------------------------------
// command  | start, busy, req               | start high and busy low
// result   | done, result                   | done high (one cycle, no stall)
// config   | cfg_write, cfg_index, cfg_data | cfg_write high
//
// Every command beat is finished directly: the free-list head, the Morton
// cursor and the prefetched link feed one stage of logic into the result
// register, so a command can be taken in every cycle outside reset.
// The result beat appears on done/result in the cycle after its command.
// rst is synchronous and active high; busy is high only while rst is held.
// The link table needs no clearing pass: per-entry valid bits stand in for
// the reset contents, so the block is ready as soon as reset is released.
// The receiver cannot stall, so nothing ever holds a command off.

module voxel_block_allocator_core #(
  parameter int POOL_SLOTS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  vba_pkg::req_t                     req,
  output logic                              done,
  output vba_pkg::rsp_t                     result,
  input  logic                              cfg_write,
  input  logic [vba_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [vba_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import vba_pkg::*;

  localparam int LINK_W = $clog2(POOL_SLOTS + 1);

  // Configuration registers.
  logic [GRID_W-1:0] grid_blocks_per_axis;
  logic [LOG2_W-1:0] block_width_log2;

  logic              accept;
  fl_cmd_t           fl_cmd;
  logic [LINK_W-1:0] head;
  logic              empty;
  logic              advance;
  logic              exhausted;
  logic [SHAMT_W-1:0] shamt;
  geom_t             geom;
  rsp_t              result_next;
  logic [HEAD_EXT_W-1:0] head_ext;
  logic [35:0]       offset_wide;

  // Commands are refused only while reset is applied.
  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_blocks_per_axis <= GRID_RESET;
      block_width_log2     <= LOG2_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GRID: grid_blocks_per_axis <= cfg_data[GRID_W-1:0];
        CFG_LOG2: block_width_log2     <= cfg_data[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // The free list holds the pool slots as a singly linked list.
  vba_free_list #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_free_list (
    .clk  (clk),
    .rst  (rst),
    .cmd  (fl_cmd),
    .head (head),
    .empty(empty)
  );

  // The cursor module checks the grid end and decodes the block geometry.
  vba_cursor #(
    .COORD_BITS(COORD_BITS)
  ) u_cursor (
    .clk                 (clk),
    .rst                 (rst),
    .advance             (advance),
    .grid_blocks_per_axis(grid_blocks_per_axis),
    .block_width_log2    (block_width_log2),
    .exhausted           (exhausted),
    .shamt               (shamt),
    .geom                (geom)
  );

  always_comb begin
    head_ext    = HEAD_EXT_W'(head);
    offset_wide = 36'(head_ext) << shamt;

    result_next = '0;
    fl_cmd      = '0;
    advance     = 1'b0;

    if (accept) begin
      case (req.op)
        OP_RELEASE: begin
          // Slots outside the pool are answered but leave the list alone.
          result_next.status = STATUS_RELEASED;
          result_next.slot   = req.release_slot;
          fl_cmd.push        = (int'(req.release_slot) < POOL_SLOTS);
          fl_cmd.slot        = req.release_slot;
        end
        OP_GENERATE: begin
          // The end of the grid is checked before the free list.
          if (exhausted) begin
            result_next.status = STATUS_EXHAUSTED;
          end else if (empty) begin
            result_next.status = STATUS_NO_SLOT;
          end else begin
            fl_cmd.pop               = 1'b1;
            advance                  = 1'b1;
            result_next.status       = STATUS_GENERATED;
            result_next.slot         = head_ext[SLOT_W-1:0];
            result_next.morton_first = geom.morton_first;
            result_next.morton_past  = geom.morton_past;
            result_next.data_offset  = offset_wide[OFFSET_W-1:0];
            result_next.origin_x     = geom.origin_x;
            result_next.origin_y     = geom.origin_y;
            result_next.origin_z     = geom.origin_z;
            result_next.block_x      = geom.block_x;
            result_next.block_y      = geom.block_y;
            result_next.block_z      = geom.block_z;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  `VBA_ASSERT_NEXT(a_done_after_accept, clk, rst, start && !busy, done, "command beat without a result beat")
  `VBA_ASSERT(a_done_has_command, clk, rst, done |-> $past(start && !busy), "result beat without a command beat")
  `VBA_ASSERT(a_gen_range_grows, clk, rst, done && result.status == STATUS_GENERATED |-> result.morton_past > CURSOR_W'(result.morton_first), "generated block has an empty Morton range")

endmodule

`default_nettype wire

[sim/tb_voxel_block_allocator_core.sv]
`timescale 1ns / 1ps

module tb_voxel_block_allocator_core;
  import vba_pkg::*;

  localparam int POOL_SLOTS = 16;
  localparam logic [4:0] NULL_LINK = 5'd16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAIN_ITEMS = 1600;
  localparam int TOTAL_ITEMS = 1750;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t result;
  logic cfg_write = 1'b0;
  cfg_index_t cfg_index = CFG_GRID;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Command beats waiting to be driven, and the result beats predicted for
  // commands already taken by the block, oldest first.
  req_t cmd_backlog[$];
  rsp_t rsp_due[$];

  // Shadow copy of the allocator: registers, Morton cursor and free list.
  logic [GRID_W-1:0] cfg_grid;
  logic [LOG2_W-1:0] cfg_lg;
  logic [CURSOR_W-1:0] alloc_cursor;
  logic [4:0] alloc_head;
  logic [4:0] alloc_link[POOL_SLOTS];
  // Slots handed out and not yet given back; the stimulus draws releases
  // from here so that most sequences stay well formed.
  logic [SLOT_W-1:0] slots_out[$];

  int cycle_count = 0;
  int mismatch_count = 0;
  int items_queued = 0;
  int reg_writes = 0;
  int n_generated = 0;
  int n_released = 0;
  int n_exhausted = 0;
  int n_no_slot = 0;
  int burst_left = 1;
  int gap_left = 0;

  voxel_block_allocator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d beats still due", cycle_count,
               rsp_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void reset_shadow();
    cfg_grid = GRID_RESET;
    cfg_lg = LOG2_RESET;
    alloc_cursor = '0;
    alloc_head = '0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      alloc_link[i] = 5'(i + 1);
    end
    slots_out.delete();
  endfunction

  function automatic logic [LOG2_W-1:0] eff_lg();
    return (cfg_lg > LOG2_MAX) ? LOG2_MAX : cfg_lg;
  endfunction

  // Spread each coordinate bit over a whole Morton triple, as the end code
  // covers the full cube of side grid * block width.
  function automatic logic [63:0] grid_end_code();
    logic [GRID_W-1:0] g;
    logic [16:0] side;
    logic [15:0] last;
    logic [63:0] code;
    g = (cfg_grid > GRID_MAX) ? GRID_MAX : cfg_grid;
    if (g == '0) return 64'd0;
    side = 17'(g) << eff_lg();
    last = 16'(side - 17'd1);
    code = '0;
    for (int i = 0; i < 16; i++) begin
      code[3*i +: 3] = {3{last[i]}};
    end
    return code + 64'd1;
  endfunction

  function automatic logic [ORIGIN_W-1:0] gather_axis(logic [FIRST_W-1:0] code, int axis);
    logic [ORIGIN_W-1:0] v;
    for (int i = 0; i < ORIGIN_W; i++) begin
      v[i] = code[3*i + axis];
    end
    return v;
  endfunction

  // Apply one command to the shadow state and return the beat it must cause.
  function automatic rsp_t predict_alloc(req_t cmd);
    rsp_t r;
    logic [LOG2_W-1:0] lg;
    logic [63:0] step;
    logic [63:0] past;
    logic [FIRST_W-1:0] first;
    logic [SLOT_W-1:0] s;
    logic [ORIGIN_W-1:0] x, y, z;
    r = '0;
    lg = eff_lg();
    step = 64'd1 << (3 * lg);
    if (cmd.op == OP_RELEASE) begin
      // A four-bit slot always lies inside the pool, so every release is pushed,
      // even one of a slot that is already free.
      alloc_link[cmd.release_slot] = alloc_head;
      alloc_head = {1'b0, cmd.release_slot};
      for (int i = 0; i < slots_out.size(); i++) begin
        if (slots_out[i] == cmd.release_slot) begin
          slots_out.delete(i);
          break;
        end
      end
      r.status = STATUS_RELEASED;
      r.slot = cmd.release_slot;
      return r;
    end
    // Range exhaustion wins over an empty free list.
    if (64'(alloc_cursor) >= grid_end_code()) begin
      r.status = STATUS_EXHAUSTED;
    end else if (alloc_head >= NULL_LINK) begin
      r.status = STATUS_NO_SLOT;
    end else begin
      s = alloc_head[SLOT_W-1:0];
      first = alloc_cursor[FIRST_W-1:0];
      past = 64'(alloc_cursor) + step;
      x = gather_axis(first, 0);
      y = gather_axis(first, 1);
      z = gather_axis(first, 2);
      alloc_head = alloc_link[s];
      alloc_cursor = past[CURSOR_W-1:0];
      slots_out.push_back(s);
      r.status = STATUS_GENERATED;
      r.slot = s;
      r.morton_first = first;
      r.morton_past = past[CURSOR_W-1:0];
      r.data_offset = OFFSET_W'(64'(s) * step);
      r.origin_x = x;
      r.origin_y = y;
      r.origin_z = z;
      r.block_x = BLOCK_W'(x >> lg);
      r.block_y = BLOCK_W'(y >> lg);
      r.block_z = BLOCK_W'(z >> lg);
    end
    return r;
  endfunction

  task automatic check_result(rsp_t got, rsp_t want);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatch_count++;
    end
    if (got.slot !== want.slot) begin
      $error("slot: expected %0d, got %0d", want.slot, got.slot);
      mismatch_count++;
    end
    if (got.morton_first !== want.morton_first) begin
      $error("morton_first: expected %0h, got %0h", want.morton_first, got.morton_first);
      mismatch_count++;
    end
    if (got.morton_past !== want.morton_past) begin
      $error("morton_past: expected %0h, got %0h", want.morton_past, got.morton_past);
      mismatch_count++;
    end
    if (got.data_offset !== want.data_offset) begin
      $error("data_offset: expected %0h, got %0h", want.data_offset, got.data_offset);
      mismatch_count++;
    end
    if (got.origin_x !== want.origin_x) begin
      $error("origin_x: expected %0d, got %0d", want.origin_x, got.origin_x);
      mismatch_count++;
    end
    if (got.origin_y !== want.origin_y) begin
      $error("origin_y: expected %0d, got %0d", want.origin_y, got.origin_y);
      mismatch_count++;
    end
    if (got.origin_z !== want.origin_z) begin
      $error("origin_z: expected %0d, got %0d", want.origin_z, got.origin_z);
      mismatch_count++;
    end
    if (got.block_x !== want.block_x) begin
      $error("block_x: expected %0d, got %0d", want.block_x, got.block_x);
      mismatch_count++;
    end
    if (got.block_y !== want.block_y) begin
      $error("block_y: expected %0d, got %0d", want.block_y, got.block_y);
      mismatch_count++;
    end
    if (got.block_z !== want.block_z) begin
      $error("block_z: expected %0d, got %0d", want.block_z, got.block_z);
      mismatch_count++;
    end
  endtask

  // Monitor. A result beat sampled here was on the ports for the whole cycle
  // that this edge ends. It is checked before the command taken at the same
  // edge is predicted, so the oldest prediction always pairs with it.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      reset_shadow();
    end else begin
      if (done) begin
        if (rsp_due.size() == 0) begin
          $error("result beat with no command outstanding: status %0d slot %0d",
                 result.status, result.slot);
          mismatch_count++;
        end else begin
          check_result(result, rsp_due.pop_front());
        end
      end
      if (cfg_write) begin
        if (cfg_index == CFG_GRID) cfg_grid = cfg_data[GRID_W-1:0];
        else cfg_lg = cfg_data[LOG2_W-1:0];
      end
      if (start && !busy) begin
        want = predict_alloc(req);
        rsp_due.push_back(want);
        void'(cmd_backlog.pop_front());
        case (want.status)
          STATUS_GENERATED: n_generated++;
          STATUS_RELEASED: n_released++;
          STATUS_EXHAUSTED: n_exhausted++;
          default: n_no_slot++;
        endcase
      end
    end
  end

  // Driver. Command beats go out in bursts of random length; an empty gap
  // joins two bursts into one longer stretch without idling.
  always @(negedge clk) begin
    if (rst || gap_left > 0 || cmd_backlog.size() == 0) begin
      start <= 1'b0;
      if (!rst && gap_left > 0) gap_left--;
    end else begin
      start <= 1'b1;
      req <= cmd_backlog[0];
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 48);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      end
    end
  end

  task automatic push_cmd(op_t op, logic [SLOT_W-1:0] slot);
    req_t c;
    c.op = op;
    c.release_slot = slot;
    cmd_backlog.push_back(c);
    items_queued++;
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    reg_writes++;
  endtask

  // Every command answers in the cycle after it is taken, so once nothing is
  // due the block is idle; the wait that follows leaves margin before a register write.
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || rsp_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // The upper data bits of a log2 write are random; only the low four count.
  task automatic pick_setting();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom());
    case ($urandom_range(0, 9))
      0: write_reg(CFG_GRID, '0);
      1: write_reg(CFG_GRID, CFG_DATA_W'($urandom_range(257, 511)));
      2: begin
        write_reg(CFG_GRID, CFG_DATA_W'($urandom_range(1, 3)));
        d[LOG2_W-1:0] = LOG2_W'($urandom_range(0, 2));
        write_reg(CFG_LOG2, d);
      end
      3: begin
        write_reg(CFG_GRID, CFG_DATA_W'(GRID_MAX));
        d[LOG2_W-1:0] = LOG2_W'($urandom_range(9, 15));
        write_reg(CFG_LOG2, d);
      end
      default: begin
        write_reg(CFG_GRID, CFG_DATA_W'($urandom_range(1, 256)));
        d[LOG2_W-1:0] = LOG2_W'($urandom_range(0, 8));
        write_reg(CFG_LOG2, d);
      end
    endcase
  endtask

  // Queue one stretch of commands. Releases give back slots that are really
  // out, and generates outrun the pool now and then to draw the no-slot
  // answer. noise_pct of the commands are fully random instead.
  task automatic queue_stretch(int n, int noise_pct);
    logic [SLOT_W-1:0] held[$];
    int free_est;
    int k;
    bit give_back;
    held = slots_out;
    free_est = POOL_SLOTS - held.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        push_cmd(op_t'($urandom_range(0, 1)), SLOT_W'($urandom()));
      end else begin
        if (held.size() == 0) give_back = 1'b0;
        else if (free_est <= 0) give_back = ($urandom_range(0, 9) < 8);
        else give_back = ($urandom_range(0, 99) < 45);
        if (give_back) begin
          k = $urandom_range(0, held.size() - 1);
          push_cmd(OP_RELEASE, held[k]);
          held.delete(k);
          free_est++;
        end else begin
          // The slot field of a generate is don't-care; it is randomized anyway.
          push_cmd(OP_GENERATE, SLOT_W'($urandom()));
          if (free_est > 0) free_est--;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default setting: drain the whole pool and one more, so the last
    // generate finds no free slot. Then return the lowest and highest slots
    // and take them again in last-in, first-out order.
    @(posedge clk);
    repeat (POOL_SLOTS + 1) push_cmd(OP_GENERATE, '0);
    push_cmd(OP_RELEASE, 4'd15);
    push_cmd(OP_RELEASE, 4'd0);
    push_cmd(OP_GENERATE, 4'd15);
    push_cmd(OP_GENERATE, 4'd0);

    // Empty grid while the pool is also empty: exhaustion must be reported.
    wait_idle();
    write_reg(CFG_GRID, '0);
    @(posedge clk);
    push_cmd(OP_GENERATE, '0);
    push_cmd(OP_RELEASE, 4'd5);

    // Oversized grid and block width, both saturated to their largest legal value.
    wait_idle();
    write_reg(CFG_GRID, '1);
    write_reg(CFG_LOG2, '1);
    @(posedge clk);
    push_cmd(OP_GENERATE, '0);
    push_cmd(OP_RELEASE, 4'd7);

    // Well-formed traffic under changing settings.
    while (items_queued < MAIN_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 3) != 0) pick_setting();
      @(posedge clk);
      queue_stretch($urandom_range(8, 40), 0);
    end

    // Random releases can push a slot that is already free, which leaves the
    // free list cyclic for good, so that noise is kept to the tail of the run.
    while (items_queued < TOTAL_ITEMS) begin
      wait_idle();
      pick_setting();
      @(posedge clk);
      queue_stretch($urandom_range(8, 40), 60);
    end

    wait_idle();
    repeat (3) @(negedge clk);
    $display("Ran %0d commands under %0d register writes: %0d blocks generated, %0d releases,",
             items_queued, reg_writes, n_generated, n_released);
    $display("%0d range-exhausted and %0d no-free-slot answers, %0d field mismatches.",
             n_exhausted, n_no_slot, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
